@@ rtl/boid_pkg.sv @@
// Shared types and constants for the BER object identifier decoder.
package boid_pkg;

    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] TAG_RESET = 8'h06;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LEN1 = 2'd1;
    localparam logic [1:0] PH_LENN = 2'd2;
    localparam logic [1:0] PH_BODY = 2'd3;

    localparam logic [1:0] ST_SUBID = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERR   = 2'd2;

    localparam logic [2:0] E_TAG   = 3'd0;
    localparam logic [2:0] E_FORM  = 3'd1;
    localparam logic [2:0] E_BIG   = 3'd2;
    localparam logic [2:0] E_TRUNC = 3'd3;
    localparam logic [2:0] E_OVF   = 3'd4;
    localparam logic [2:0] E_UNFIN = 3'd5;

    // classified byte request
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       blast;
        logic       tag_ok;
        logic       more;
        logic       form_ok;
    } item_t;

endpackage

@@ rtl/ber_object_identifier_decoder.sv @@
// Top level of the BER object identifier decoder.
// A byte is queued, and any result it yields is held in the result register.
// Throughput: one byte per cycle, retired by the engine unless the output stalls.
// A two-entry queue and the result register absorb output stalls.
// Reset (rst_n low, asynchronous): engine idle, queue empty, expected tag 0x06.
module ber_object_identifier_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_req,
    input  logic        buffer_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] subid_value,
    output logic [30:0] subid_count,
    output logic [2:0]  error_code,
    output logic        last
);

    logic            push;
    boid_pkg::item_t push_item;
    logic            q_ready;
    logic            pop;
    logic            q_valid;
    boid_pkg::item_t q_item;

    boid_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .start_req   (start_req),
        .buffer_last (buffer_last),
        .push        (push),
        .push_item   (push_item),
        .q_ready     (q_ready)
    );

    boid_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    boid_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .subid_value (subid_value),
        .subid_count (subid_count),
        .error_code  (error_code),
        .last        (last)
    );

endmodule

@@ rtl/boid_front.sv @@
// Front end: accepts byte requests, holds the tag register and classifies each byte.
module boid_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        data_byte,
    input  logic              start_req,
    input  logic              buffer_last,
    output logic              push,
    output boid_pkg::item_t   push_item,
    input  logic              q_ready
);

    logic [7:0] tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= boid_pkg::TAG_RESET;
        end
        else if (cfg_we)
        begin
            tag_reg <= cfg_wdata;
        end
    end

    assign in_ready = q_ready;
    assign push     = in_valid && q_ready;

    always_comb
    begin
        push_item.data    = data_byte;
        push_item.start   = start_req;
        push_item.blast   = buffer_last;
        push_item.tag_ok  = (data_byte == tag_reg);
        push_item.more    = data_byte[7];
        // long form with one to four length octets
        push_item.form_ok = (data_byte[6:0] != 7'd0) && (data_byte[6:0] <= 7'd4);
    end

endmodule

@@ rtl/boid_queue.sv @@
// Two-entry queue between the classifier and the decode engine.
module boid_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  boid_pkg::item_t   push_item,
    output logic              q_ready,
    input  logic              pop,
    output logic              q_valid,
    output boid_pkg::item_t   q_item
);

    boid_pkg::item_t                    mem [boid_pkg::QDEPTH];
    logic [boid_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [boid_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [boid_pkg::QCNT_W-1:0]        cnt_reg;

    localparam logic [boid_pkg::QCNT_W-1:0] FULL = boid_pkg::QCNT_W'(boid_pkg::QDEPTH);
    localparam logic [boid_pkg::QPTR_W-1:0] LAST = boid_pkg::QPTR_W'(boid_pkg::QDEPTH - 1);

    assign q_ready = (cnt_reg != FULL);
    assign q_valid = (cnt_reg != '0);
    assign q_item  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/boid_back.sv @@
// Decode engine: length and subidentifier state machine with the result register.
module boid_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  boid_pkg::item_t   q_item,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [31:0]       subid_value,
    output logic [30:0]       subid_count,
    output logic [2:0]        error_code,
    output logic              last
);

    logic [1:0]  phase_reg,       phase_next;
    logic [2:0]  len_left_reg,    len_left_next;
    logic [31:0] len_acc_reg,     len_acc_next;
    logic [30:0] content_reg,     content_next;
    logic [31:0] subid_acc_reg,   subid_acc_next;
    logic [30:0] count_reg,       count_next;

    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [31:0] value_reg;
    logic [30:0] cnt_out_reg;
    logic [2:0]  code_reg;
    logic        last_reg;

    logic        res_v;
    logic [1:0]  res_status;
    logic [31:0] res_value;
    logic [30:0] res_count;
    logic [2:0]  res_code;
    logic        res_last;

    logic [31:0] len_shift;
    logic [2:0]  len_left_dec;
    logic [30:0] len_val;
    logic        body_end;
    logic [31:0] subid_new;

    assign pop = q_valid && (!out_valid_reg || out_ready);

    assign len_shift    = {len_acc_reg[23:0], q_item.data};
    assign len_left_dec = len_left_reg - 3'd1;
    assign body_end     = (content_reg == 31'd1);
    assign subid_new    = {subid_acc_reg[24:0], q_item.data[6:0]};

    always_comb
    begin
        phase_next     = phase_reg;
        len_left_next  = len_left_reg;
        len_acc_next   = len_acc_reg;
        content_next   = content_reg;
        subid_acc_next = subid_acc_reg;
        count_next     = count_reg;
        res_v          = 1'b0;
        res_status     = boid_pkg::ST_ERR;
        res_value      = '0;
        res_count      = count_reg;
        res_code       = boid_pkg::E_TAG;
        res_last       = 1'b1;
        len_val        = '0;

        if (pop)
        begin
            if (q_item.start)
            begin
                count_next     = '0;
                subid_acc_next = '0;
                len_acc_next   = '0;
                len_left_next  = '0;
                content_next   = '0;
                res_count      = '0;
                if (!q_item.tag_ok)
                begin
                    res_v      = 1'b1;
                    phase_next = boid_pkg::PH_IDLE;
                end
                else if (q_item.blast)
                begin
                    res_v      = 1'b1;
                    res_code   = boid_pkg::E_TRUNC;
                    phase_next = boid_pkg::PH_IDLE;
                end
                else
                begin
                    phase_next = boid_pkg::PH_LEN1;
                end
            end
            else
            begin
                unique case (phase_reg)
                    boid_pkg::PH_LEN1:
                    begin
                        if (!q_item.more)
                        begin
                            len_val      = {24'd0, q_item.data[6:0]};
                            content_next = len_val;
                            if (len_val == '0)
                            begin
                                res_v      = 1'b1;
                                res_status = boid_pkg::ST_DONE;
                                phase_next = boid_pkg::PH_IDLE;
                            end
                            else if (q_item.blast)
                            begin
                                res_v      = 1'b1;
                                res_code   = boid_pkg::E_TRUNC;
                                phase_next = boid_pkg::PH_IDLE;
                            end
                            else
                            begin
                                phase_next = boid_pkg::PH_BODY;
                            end
                        end
                        else if (!q_item.form_ok)
                        begin
                            res_v      = 1'b1;
                            res_code   = boid_pkg::E_FORM;
                            phase_next = boid_pkg::PH_IDLE;
                        end
                        else if (q_item.blast)
                        begin
                            res_v      = 1'b1;
                            res_code   = boid_pkg::E_TRUNC;
                            phase_next = boid_pkg::PH_IDLE;
                        end
                        else
                        begin
                            len_left_next = q_item.data[2:0];
                            len_acc_next  = '0;
                            phase_next    = boid_pkg::PH_LENN;
                        end
                    end
                    boid_pkg::PH_LENN:
                    begin
                        len_acc_next  = len_shift;
                        len_left_next = len_left_dec;
                        len_val       = len_shift[30:0];
                        if (len_left_dec != 3'd0)
                        begin
                            if (q_item.blast)
                            begin
                                res_v      = 1'b1;
                                res_code   = boid_pkg::E_TRUNC;
                                phase_next = boid_pkg::PH_IDLE;
                            end
                        end
                        else if (len_shift[31])
                        begin
                            res_v      = 1'b1;
                            res_code   = boid_pkg::E_BIG;
                            phase_next = boid_pkg::PH_IDLE;
                        end
                        else
                        begin
                            content_next = len_val;
                            if (len_val == '0)
                            begin
                                res_v      = 1'b1;
                                res_status = boid_pkg::ST_DONE;
                                phase_next = boid_pkg::PH_IDLE;
                            end
                            else if (q_item.blast)
                            begin
                                res_v      = 1'b1;
                                res_code   = boid_pkg::E_TRUNC;
                                phase_next = boid_pkg::PH_IDLE;
                            end
                            else
                            begin
                                phase_next = boid_pkg::PH_BODY;
                            end
                        end
                    end
                    boid_pkg::PH_BODY:
                    begin
                        content_next = content_reg - 31'd1;
                        if (!body_end && q_item.blast)
                        begin
                            res_v      = 1'b1;
                            res_code   = boid_pkg::E_TRUNC;
                            phase_next = boid_pkg::PH_IDLE;
                        end
                        else if (body_end && q_item.more)
                        begin
                            res_v      = 1'b1;
                            res_code   = boid_pkg::E_UNFIN;
                            phase_next = boid_pkg::PH_IDLE;
                        end
                        else if (subid_acc_reg[31:25] != 7'd0)
                        begin
                            res_v      = 1'b1;
                            res_code   = boid_pkg::E_OVF;
                            phase_next = boid_pkg::PH_IDLE;
                        end
                        else if (q_item.more)
                        begin
                            subid_acc_next = subid_new;
                        end
                        else
                        begin
                            subid_acc_next = '0;
                            count_next     = count_reg + 31'd1;
                            res_v          = 1'b1;
                            res_status     = boid_pkg::ST_SUBID;
                            res_value      = subid_new;
                            res_count      = count_reg + 31'd1;
                            res_last       = body_end;
                            if (body_end)
                            begin
                                phase_next = boid_pkg::PH_IDLE;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = boid_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= boid_pkg::PH_IDLE;
            len_left_reg  <= '0;
            len_acc_reg   <= '0;
            content_reg   <= '0;
            subid_acc_reg <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            len_left_reg  <= len_left_next;
            len_acc_reg   <= len_acc_next;
            content_reg   <= content_next;
            subid_acc_reg <= subid_acc_next;
            count_reg     <= count_next;
            if (res_v)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_v)
        begin
            status_reg  <= res_status;
            value_reg   <= res_value;
            cnt_out_reg <= res_count;
            code_reg    <= (res_status == boid_pkg::ST_ERR) ? res_code : boid_pkg::E_TAG;
            last_reg    <= res_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign subid_value = value_reg;
    assign subid_count = cnt_out_reg;
    assign error_code  = code_reg;
    assign last        = last_reg;

    a_final_ends_element: assert property (@(posedge clk) disable iff (!rst_n)
        (res_v && res_last) |=> (phase_reg == boid_pkg::PH_IDLE))
        else $error("element not closed after final result");

    a_nonsubid_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != boid_pkg::ST_SUBID) |->
            (last_reg && value_reg == 32'd0))
        else $error("done or error result not final or carries a value");

    a_subid_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == boid_pkg::ST_SUBID) |->
            (cnt_out_reg != 31'd0 && code_reg == boid_pkg::E_TAG))
        else $error("subidentifier result with zero count or error code");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !pop)
        else $error("request taken while result register stalled");

endmodule

@@ test/tb.sv @@
// Testbench for the BER OID decoder: directed and random byte streams checked by a scoreboard.
`timescale 1ns / 1ps

module tb;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] value;
        logic [30:0] count;
        logic [2:0]  code;
        logic        last;
    } oid_result_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       blast;
    } byte_req_t;

    class oid_scoreboard;
        logic [7:0]  tag;
        logic [1:0]  phase;
        logic [2:0]  len_left;
        logic [31:0] len_acc;
        logic [30:0] content_left;
        logic [31:0] subid_acc;
        logic [30:0] count;
        oid_result_t expected_q[$];
        int          errors;

        function new();
            tag = boid_pkg::TAG_RESET;
            phase = boid_pkg::PH_IDLE;
            len_left = '0;
            len_acc = '0;
            content_left = '0;
            subid_acc = '0;
            count = '0;
            errors = 0;
        endfunction

        function bit fault(logic [2:0] c, output oid_result_t r);
            phase = boid_pkg::PH_IDLE;
            r = oid_result_t'{boid_pkg::ST_ERR, '0, count, c, 1'b1};
            return 1;
        endfunction

        function bit header_done(logic [30:0] len, bit b, output oid_result_t r);
            content_left = len;
            if (len == 0) begin
                phase = boid_pkg::PH_IDLE;
                r = oid_result_t'{boid_pkg::ST_DONE, '0, count, '0, 1'b1};
                return 1;
            end
            if (b)
                return fault(boid_pkg::E_TRUNC, r);
            phase = boid_pkg::PH_BODY;
            return 0;
        endfunction

        function bit decode(logic [7:0] d, bit s, bit b, output oid_result_t r);
            logic [38:0] acc;
            bit          more;
            r = oid_result_t'{'0, '0, '0, '0, 1'b0};
            if (s) begin
                count = '0;
                subid_acc = '0;
                len_acc = '0;
                len_left = '0;
                content_left = '0;
                if (d != tag)
                    return fault(boid_pkg::E_TAG, r);
                if (b)
                    return fault(boid_pkg::E_TRUNC, r);
                phase = boid_pkg::PH_LEN1;
                return 0;
            end
            case (phase)
                boid_pkg::PH_LEN1:
                begin
                    if (!d[7])
                        return header_done({24'd0, d[6:0]}, b, r);
                    if (d[6:0] == 0 || d[6:0] > 4)
                        return fault(boid_pkg::E_FORM, r);
                    if (b)
                        return fault(boid_pkg::E_TRUNC, r);
                    len_left = d[2:0];
                    len_acc = '0;
                    phase = boid_pkg::PH_LENN;
                    return 0;
                end
                boid_pkg::PH_LENN:
                begin
                    len_acc = {len_acc[23:0], d};
                    len_left = len_left - 3'd1;
                    if (len_left != 0) begin
                        if (b)
                            return fault(boid_pkg::E_TRUNC, r);
                        return 0;
                    end
                    if (len_acc[31])
                        return fault(boid_pkg::E_BIG, r);
                    return header_done(len_acc[30:0], b, r);
                end
                boid_pkg::PH_BODY:
                begin
                    more = d[7];
                    content_left = content_left - 31'd1;
                    if (content_left != 0 && b)
                        return fault(boid_pkg::E_TRUNC, r);
                    if (content_left == 0 && more)
                        return fault(boid_pkg::E_UNFIN, r);
                    acc = {subid_acc, 7'd0} | {32'd0, d[6:0]};
                    if (acc[38:32] != 0)
                        return fault(boid_pkg::E_OVF, r);
                    if (more) begin
                        subid_acc = acc[31:0];
                        return 0;
                    end
                    subid_acc = '0;
                    count = count + 31'd1;
                    r = oid_result_t'{boid_pkg::ST_SUBID, acc[31:0], count, '0,
                                      content_left == 0};
                    if (content_left == 0)
                        phase = boid_pkg::PH_IDLE;
                    return 1;
                end
                default:
                begin
                    phase = boid_pkg::PH_IDLE;
                    return 0;
                end
            endcase
        endfunction

        function void note_request(logic [7:0] d, bit s, bit b);
            oid_result_t r;
            if (decode(d, s, b, r))
                expected_q.push_back(r);
        endfunction

        function void check_result(oid_result_t got);
            oid_result_t e;
            if (expected_q.size() == 0) begin
                $error("result with nothing pending: status %0d value %0h",
                       got.status, got.value);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.status !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, got.status);
                errors++;
            end
            if (got.value !== e.value) begin
                $error("subid_value: expected %0h, actual %0h", e.value, got.value);
                errors++;
            end
            if (got.count !== e.count) begin
                $error("subid_count: expected %0d, actual %0d", e.count, got.count);
                errors++;
            end
            if (got.code !== e.code) begin
                $error("error_code: expected %0d, actual %0d", e.code, got.code);
                errors++;
            end
            if (got.last !== e.last) begin
                $error("last: expected %0d, actual %0d", e.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = '0;
    logic        start_req = 1'b0;
    logic        buffer_last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [31:0] subid_value;
    logic [30:0] subid_count;
    logic [2:0]  error_code;
    logic        last;

    oid_scoreboard sb = new();
    byte_req_t     stream_q[$];
    bit            tx_idle_on = 1'b1;
    bit            rx_idle_on = 1'b1;
    int            rx_hold_cycles = 0;
    int            bytes_sent = 0;

    ber_object_identifier_decoder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .start_req  (start_req),
        .buffer_last(buffer_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .subid_value(subid_value),
        .subid_count(subid_count),
        .error_code (error_code),
        .last       (last)
    );

    always #2 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_request(data_byte, start_req, buffer_last);
        if (rst_n && out_valid && out_ready)
            sb.check_result(oid_result_t'{status, subid_value, subid_count, error_code, last});
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0) begin
                out_ready <= 1'b0;
                rx_hold_cycles--;
            end
            else
                out_ready <= !(rx_idle_on && $urandom_range(99) < 10);
        end
    end

    function void push_req(logic [7:0] d, bit s, bit b);
        stream_q.push_back(byte_req_t'{d, s, b});
    endfunction

    function void push_elem(logic [7:0] seq[$], bit blast_end);
        foreach (seq[i])
            push_req(seq[i], i == 0, blast_end && i == seq.size() - 1);
    endfunction

    // well-formed element, optionally ending in an oversize subidentifier
    function void push_oid(int nsub, bit ovf, bit blast_end);
        logic [7:0]  body[$];
        logic [31:0] v;
        logic [31:0] tmp;
        int          groups;
        int          pad;
        int          n;
        int          len;
        for (int i = 0; i < nsub; i++) begin
            if (ovf && i == nsub - 1) begin
                body.push_back(8'h80 | 8'($urandom_range(16, 127)));
                repeat (3) body.push_back(8'h80 | 8'($urandom_range(0, 127)));
                body.push_back(8'($urandom_range(0, 127)));
                continue;
            end
            case ($urandom_range(0, 3))
                0: v = $urandom_range(0, 127);
                1: v = $urandom_range(128, 16383);
                2: v = $urandom;
                default: v = $urandom >> $urandom_range(0, 31);
            endcase
            groups = 1;
            while (groups < 5 && (v >> (7 * groups)) != 0)
                groups++;
            pad = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
            repeat (pad) body.push_back(8'h80);
            for (int g = groups - 1; g >= 0; g--) begin
                tmp = v >> (7 * g);
                body.push_back({g != 0, tmp[6:0]});
            end
        end
        len = body.size();
        push_req(sb.tag, 1'b1, 1'b0);
        if ($urandom_range(0, 3) != 0)
            push_req(8'(len), 1'b0, 1'b0);
        else begin
            n = $urandom_range(1, 4);
            push_req(8'h80 | 8'(n), 1'b0, 1'b0);
            for (int k = n - 1; k >= 0; k--)
                push_req(8'(len >> (8 * k)), 1'b0, 1'b0);
        end
        foreach (body[i])
            push_req(body[i], 1'b0, blast_end && i == len - 1);
        if (len == 0 && blast_end)
            stream_q[stream_q.size() - 1].blast = 1'b1;
    endfunction

    task send_byte(byte_req_t r);
        @(negedge clk);
        if (tx_idle_on)
            while ($urandom_range(99) < 10)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        in_valid <= 1'b1;
        data_byte <= r.data;
        start_req <= r.start;
        buffer_last <= r.blast;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task send_stream();
        foreach (stream_q[i])
            send_byte(stream_q[i]);
        stream_q.delete();
    endtask

    task wait_drained();
        int guard;
        guard = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (8) @(negedge clk);
    endtask

    task write_tag(logic [7:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.tag = v;
    endtask

    task run_random(int n_bytes);
        int stop;
        int base;
        int k;
        int kind;
        stop = bytes_sent + n_bytes;
        while (bytes_sent < stop)
        begin
            base = stream_q.size();
            kind = $urandom_range(0, 99);
            if (kind < 95) begin
                if (kind >= 66 && kind < 74)
                    push_oid($urandom_range(1, 4), 1'b1, 1'b0);
                else
                    push_oid($urandom_range(0, 6), 1'b0, $urandom_range(0, 3) == 0);
                k = $urandom_range(base, stream_q.size() - 1);
                if (kind >= 74 && kind < 82) begin
                    // buffer ends early
                    stream_q[k].blast = 1'b1;
                    while (stream_q.size() > k + 1)
                        void'(stream_q.pop_back());
                end
                else if (kind >= 82 && kind < 87) begin
                    // abandoned; next element restarts
                    while (stream_q.size() > k + 1)
                        void'(stream_q.pop_back());
                end
                else if (kind >= 87 && kind < 91)
                    stream_q[k].data = 8'($urandom);
                else if (kind >= 91 && stream_q.size() - base > 2)
                    stream_q[stream_q.size() - 1].data[7] = 1'b1;
                bytes_sent += stream_q.size();
            end
            else
                repeat ($urandom_range(1, 4))
                    push_req(8'($urandom), $urandom_range(0, 9) == 0,
                             $urandom_range(0, 1) == 1);
            send_stream();
        end
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        push_req(8'h06, 1'b0, 1'b0);
        push_elem('{8'h07}, 1'b0);
        push_elem('{8'h06}, 1'b1);
        push_elem('{8'h06, 8'h00}, 1'b0);
        push_elem('{8'h06, 8'h80}, 1'b0);
        push_elem('{8'h06, 8'h84, 8'h80, 8'h00, 8'h00, 8'h00}, 1'b0);
        push_elem('{8'h06, 8'h06, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h81}, 1'b0);
        push_elem('{8'h06, 8'h05, 8'h90, 8'h80, 8'h80, 8'h80, 8'h00}, 1'b0);
        push_elem('{8'h06, 8'h82, 8'h00, 8'h04, 8'h80, 8'h01, 8'h00, 8'h7F}, 1'b1);
        push_elem('{8'h06, 8'h03, 8'h01, 8'h02}, 1'b1);
        push_elem('{8'h06, 8'h05, 8'h01}, 1'b0);
        push_elem('{8'h06, 8'h81}, 1'b1);
        send_stream();
        wait_drained();

        write_tag(8'($urandom));
        run_random(150);
        wait_drained();

        // no idling, with a long receiver hold-off
        write_tag(8'h00);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        rx_hold_cycles = 150;
        run_random(120);
        wait_drained();

        write_tag(8'hFF);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        run_random(60);
        wait_drained();
        run_random(60);
        wait_drained();

        write_tag(8'($urandom));
        run_random(110);
        wait_drained();

        if (sb.expected_q.size() != 0) begin
            $error("%0d results never arrived", sb.expected_q.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
